/* sv/twd_pkg.sv */
// Shared types, codes and default sizes of the task/worker dispatcher.
`default_nettype none

package twd_pkg;

  localparam int OP_W       = 3;
  localparam int TASK_W     = 8;
  localparam int WID_W      = 3;
  localparam int STATUS_W   = 4;
  localparam int MAXW_W     = 4;

  localparam int PENDING_DEPTH_DEF = 16;
  localparam int WORKER_LIMIT_DEF  = 8;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [MAXW_W-1:0] MAXW_RESET = 4'd8;

  typedef enum logic [OP_W-1:0] {
    OP_SUBMIT     = 3'd0,
    OP_SUBMIT_IMM = 3'd1,
    OP_REMOVE     = 3'd2,
    OP_CLEAR      = 3'd3,
    OP_DONE       = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    K_SUBMIT     = 3'd0,
    K_SUBMIT_IMM = 3'd1,
    K_REMOVE     = 3'd2,
    K_CLEAR      = 3'd3,
    K_DONE       = 3'd4,
    K_BAD        = 3'd5
  } cmd_kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_TO_IDLE   = 4'd0,
    STS_TO_NEW    = 4'd1,
    STS_QUEUED    = 4'd2,
    STS_REJECTED  = 4'd3,
    STS_DROPPED   = 4'd4,
    STS_REMOVED   = 4'd5,
    STS_NOT_FOUND = 4'd6,
    STS_CLEARED   = 4'd7,
    STS_IDLED     = 4'd8
  } status_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [TASK_W-1:0]  task_id;
    logic [WID_W-1:0]   worker_id;
  } cmd_t;

  typedef struct packed {
    status_e            status;
    logic               assign_valid;
    logic [WID_W-1:0]   assign_worker;
    logic [TASK_W-1:0]  assign_task;
  } res_t;

endpackage

`default_nettype wire

/* sv/twd_fifo.sv */
// Small flop-based queue used between front and back and at the result side.
`default_nettype none

module twd_fifo
  import twd_pkg::*;
#(
  parameter type T     = cmd_t,
  parameter int  DEPTH = QUEUE_DEPTH
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  push_i,
  input  T     data_i,
  output logic full_o,
  input  wire  pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T mem_q [DEPTH];

  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
    end
    cnt_d = cnt_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* sv/twd_front.sv */
// Front end: takes input beats and decodes the op into a command for the back end.
`default_nettype none

module twd_front
  import twd_pkg::*;
(
  input  wire               push_i,
  output logic              full_o,
  input  wire  [OP_W-1:0]   op_i,
  input  wire  [TASK_W-1:0] task_id_i,
  input  wire  [WID_W-1:0]  worker_id_i,
  output logic              cmd_push_o,
  output cmd_t              cmd_o,
  input  wire               cmd_full_i
);

  assign full_o     = cmd_full_i;
  assign cmd_push_o = push_i;

  always_comb begin
    cmd_o.task_id   = task_id_i;
    cmd_o.worker_id = worker_id_i;
    case (op_i)
      OP_SUBMIT:     cmd_o.kind = K_SUBMIT;
      OP_SUBMIT_IMM: cmd_o.kind = K_SUBMIT_IMM;
      OP_REMOVE:     cmd_o.kind = K_REMOVE;
      OP_CLEAR:      cmd_o.kind = K_CLEAR;
      OP_DONE:       cmd_o.kind = K_DONE;
      default:       cmd_o.kind = K_BAD;
    endcase
  end

endmodule

`default_nettype wire

/* sv/twd_engine.sv */
// Back end: pending-task ring, idle-worker ring, worker count and command sequencer.
`default_nettype none

module twd_engine
  import twd_pkg::*;
#(
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
  parameter int WORKER_LIMIT  = WORKER_LIMIT_DEF
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  wire  [MAXW_W-1:0] cfg_data_i,
  input  cmd_t              cmd_i,
  input  wire               cmd_empty_i,
  output logic              cmd_pop_o,
  output res_t              res_o,
  input  wire               res_full_i,
  output logic              res_push_o
);

  localparam int PW  = $clog2(PENDING_DEPTH);
  localparam int PCW = $clog2(PENDING_DEPTH + 1);
  localparam int IW  = (WORKER_LIMIT > 1) ? $clog2(WORKER_LIMIT) : 1;
  localparam int ICW = $clog2(WORKER_LIMIT + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_DRD   = 6'b000100,
    S_SRCH  = 6'b001000,
    S_SHIFT = 6'b010000,
    S_EMIT  = 6'b100000
  } state_e;

  function automatic logic [PW-1:0] p_wrap(input logic [PW:0] s);
    logic [PW:0] r;
    r = (s >= (PW+1)'(PENDING_DEPTH)) ? s - (PW+1)'(PENDING_DEPTH) : s;
    return r[PW-1:0];
  endfunction

  function automatic logic [IW-1:0] i_wrap(input logic [IW:0] s);
    logic [IW:0] r;
    r = (s >= (IW+1)'(WORKER_LIMIT)) ? s - (IW+1)'(WORKER_LIMIT) : s;
    return r[IW-1:0];
  endfunction

  state_e state_q, state_d;
  cmd_t   cmd_q, cmd_d;
  res_t   res_q, res_d;

  logic [PW-1:0]     p_head_q, p_head_d;
  logic [PCW-1:0]    p_cnt_q, p_cnt_d;
  logic [PCW-1:0]    idx_q, idx_d;
  logic [IW-1:0]     i_head_q, i_head_d;
  logic [ICW-1:0]    i_cnt_q, i_cnt_d;
  logic [ICW-1:0]    started_q, started_d;
  logic [MAXW_W-1:0] max_workers_q;

  // pending store
  logic [TASK_W-1:0] pend_mem [PENDING_DEPTH];
  logic              p_we, p_re;
  logic [PW-1:0]     p_waddr, p_raddr;
  logic [TASK_W-1:0] p_wdata, p_rdata_q;

  // idle worker store
  logic [WID_W-1:0]  idle_mem [WORKER_LIMIT];
  logic              i_we, i_re;
  logic [IW-1:0]     i_waddr;
  logic [WID_W-1:0]  i_rdata_q;

  logic [7:0]     started8, cap8, maxw8, lim8;
  logic [PCW:0]   idx_p1, idx_p2;

  assign maxw8    = 8'(max_workers_q);
  assign lim8     = 8'(WORKER_LIMIT);
  assign cap8     = (maxw8 < lim8) ? maxw8 : lim8;
  assign started8 = 8'(started_q);
  assign idx_p1   = (PCW+1)'(idx_q) + (PCW+1)'(1);
  assign idx_p2   = (PCW+1)'(idx_q) + (PCW+1)'(2);

  assign res_o = res_q;

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    res_d      = res_q;
    p_head_d   = p_head_q;
    p_cnt_d    = p_cnt_q;
    idx_d      = idx_q;
    i_head_d   = i_head_q;
    i_cnt_d    = i_cnt_q;
    started_d  = started_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    p_we       = 1'b0;
    p_re       = 1'b0;
    p_waddr    = p_head_q;
    p_raddr    = p_head_q;
    p_wdata    = cmd_q.task_id;
    i_we       = 1'b0;
    i_re       = 1'b0;
    i_waddr    = i_head_q;

    case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          i_re      = 1'b1;
          state_d   = S_EXEC;
        end
      end

      S_EXEC: begin
        res_d   = '{status: STS_REJECTED, assign_valid: 1'b0,
                    assign_worker: '0, assign_task: '0};
        state_d = S_EMIT;
        case (cmd_q.kind)
          K_SUBMIT, K_SUBMIT_IMM: begin
            if (i_cnt_q != '0) begin
              res_d    = '{status: STS_TO_IDLE, assign_valid: 1'b1,
                           assign_worker: i_rdata_q, assign_task: cmd_q.task_id};
              i_head_d = i_wrap((IW+1)'(i_head_q) + (IW+1)'(1));
              i_cnt_d  = i_cnt_q - ICW'(1);
            end else if (started8 < cap8) begin
              res_d     = '{status: STS_TO_NEW, assign_valid: 1'b1,
                            assign_worker: started8[WID_W-1:0],
                            assign_task: cmd_q.task_id};
              started_d = started_q + ICW'(1);
            end else if (cmd_q.kind == K_SUBMIT_IMM) begin
              res_d.status = STS_REJECTED;
            end else if (p_cnt_q < PCW'(PENDING_DEPTH)) begin
              p_we         = 1'b1;
              p_waddr      = p_wrap((PW+1)'(p_head_q) + (PW+1)'(p_cnt_q));
              p_cnt_d      = p_cnt_q + PCW'(1);
              res_d.status = STS_QUEUED;
            end else begin
              res_d.status = STS_DROPPED;
            end
          end
          K_REMOVE: begin
            if (p_cnt_q == '0) begin
              res_d.status = STS_NOT_FOUND;
            end else begin
              p_re    = 1'b1;
              idx_d   = '0;
              state_d = S_SRCH;
            end
          end
          K_CLEAR: begin
            p_cnt_d      = '0;
            res_d.status = STS_CLEARED;
          end
          K_DONE: begin
            if (p_cnt_q != '0) begin
              p_re    = 1'b1;
              state_d = S_DRD;
            end else begin
              if (i_cnt_q < ICW'(WORKER_LIMIT)) begin
                i_we    = 1'b1;
                i_waddr = i_wrap((IW+1)'(i_head_q) + (IW+1)'(i_cnt_q));
                i_cnt_d = i_cnt_q + ICW'(1);
              end
              res_d.status = STS_IDLED;
            end
          end
          default: res_d.status = STS_REJECTED;
        endcase
      end

      S_DRD: begin
        res_d    = '{status: STS_TO_IDLE, assign_valid: 1'b1,
                     assign_worker: cmd_q.worker_id, assign_task: p_rdata_q};
        p_head_d = p_wrap((PW+1)'(p_head_q) + (PW+1)'(1));
        p_cnt_d  = p_cnt_q - PCW'(1);
        state_d  = S_EMIT;
      end

      // p_rdata_q holds entry idx_q (offset from head)
      S_SRCH: begin
        res_d = '{status: STS_NOT_FOUND, assign_valid: 1'b0,
                  assign_worker: '0, assign_task: '0};
        if (p_rdata_q == cmd_q.task_id) begin
          if (idx_p1 == (PCW+1)'(p_cnt_q)) begin
            p_cnt_d      = p_cnt_q - PCW'(1);
            res_d.status = STS_REMOVED;
            state_d      = S_EMIT;
          end else begin
            p_re    = 1'b1;
            p_raddr = p_wrap((PW+1)'(p_head_q) + (PW+1)'(idx_p1));
            state_d = S_SHIFT;
          end
        end else if (idx_p1 < (PCW+1)'(p_cnt_q)) begin
          p_re    = 1'b1;
          p_raddr = p_wrap((PW+1)'(p_head_q) + (PW+1)'(idx_p1));
          idx_d   = idx_p1[PCW-1:0];
        end else begin
          state_d = S_EMIT;
        end
      end

      // p_rdata_q holds entry idx_q+1, moved down into idx_q
      S_SHIFT: begin
        p_we    = 1'b1;
        p_waddr = p_wrap((PW+1)'(p_head_q) + (PW+1)'(idx_q));
        p_wdata = p_rdata_q;
        if (idx_p2 < (PCW+1)'(p_cnt_q)) begin
          p_re    = 1'b1;
          p_raddr = p_wrap((PW+1)'(p_head_q) + (PW+1)'(idx_p2));
          idx_d   = idx_p1[PCW-1:0];
        end else begin
          p_cnt_d      = p_cnt_q - PCW'(1);
          res_d        = '{status: STS_REMOVED, assign_valid: 1'b0,
                           assign_worker: '0, assign_task: '0};
          state_d      = S_EMIT;
        end
      end

      S_EMIT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (!cmd_empty_i) begin
            cmd_pop_o = 1'b1;
            cmd_d     = cmd_i;
            i_re      = 1'b1;
            state_d   = S_EXEC;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      p_head_q      <= '0;
      p_cnt_q       <= '0;
      idx_q         <= '0;
      i_head_q      <= '0;
      i_cnt_q       <= '0;
      started_q     <= '0;
      max_workers_q <= MAXW_RESET;
    end else begin
      state_q   <= state_d;
      p_head_q  <= p_head_d;
      p_cnt_q   <= p_cnt_d;
      idx_q     <= idx_d;
      i_head_q  <= i_head_d;
      i_cnt_q   <= i_cnt_d;
      started_q <= started_d;
      if (cfg_we_i) begin
        max_workers_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      pend_mem[p_waddr] <= p_wdata;
    end
    if (p_re) begin
      p_rdata_q <= pend_mem[p_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (i_we) begin
      idle_mem[i_waddr] <= cmd_q.worker_id;
    end
    if (i_re) begin
      i_rdata_q <= idle_mem[i_head_q];
    end
  end

endmodule

`default_nettype wire

/* sv/task_worker_dispatcher.sv */
// Task/worker dispatcher top level: front decode, command queue, engine, result queue.
// Path: command queue, engine and its result register, then result queue and the result ports.
// Engine steps: execute, then hand off once the result queue has room, popping the next command
//   as it hands off; a worker done with a pending task also reads the store; remove searches
//   up to the match and shifts the entries behind it, one memory read per cycle on the store.
// Reset: async active low clears queues, counts and heads, max_workers returns to 8;
//   task and worker stores are not cleared, so no pass runs after reset.
`default_nettype none

module task_worker_dispatcher
  import twd_pkg::*;
#(
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
  parameter int WORKER_LIMIT  = WORKER_LIMIT_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push,
  output logic                full,
  input  wire  [OP_W-1:0]     op_i,
  input  wire  [TASK_W-1:0]   task_id_i,
  input  wire  [WID_W-1:0]    worker_id_i,
  output logic                empty,
  input  wire                 pop,
  output logic [STATUS_W-1:0] status_o,
  output logic                assign_valid_o,
  output logic [WID_W-1:0]    assign_worker_o,
  output logic [TASK_W-1:0]   assign_task_o,
  input  wire                 cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire  [MAXW_W-1:0]   cfg_max_workers_i
);

  cmd_t front_cmd, eng_cmd;
  res_t eng_res, out_res;
  logic front_push, cmd_full, cmd_empty, cmd_pop;
  logic res_full, res_push;

  assign cfg_ready_o = 1'b1;

  twd_front u_front (
    .push_i      (push),
    .full_o      (full),
    .op_i        (op_i),
    .task_id_i   (task_id_i),
    .worker_id_i (worker_id_i),
    .cmd_push_o  (front_push),
    .cmd_o       (front_cmd),
    .cmd_full_i  (cmd_full)
  );

  twd_fifo #(
    .T     (cmd_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (eng_cmd),
    .empty_o (cmd_empty)
  );

  twd_engine #(
    .PENDING_DEPTH (PENDING_DEPTH),
    .WORKER_LIMIT  (WORKER_LIMIT)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_max_workers_i),
    .cmd_i       (eng_cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (eng_res),
    .res_full_i  (res_full),
    .res_push_o  (res_push)
  );

  twd_fifo #(
    .T     (res_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (eng_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_res),
    .empty_o (empty)
  );

  assign status_o        = out_res.status;
  assign assign_valid_o  = out_res.assign_valid;
  assign assign_worker_o = out_res.assign_worker;
  assign assign_task_o   = out_res.assign_task;

endmodule

`default_nettype wire

/* dv/task_worker_dispatcher_tb.sv */
// Self-checking testbench for the task/worker dispatcher: queue-style driver, monitor, predictor.
`default_nettype none

module task_worker_dispatcher_tb;
  import twd_pkg::*;

  localparam int HALF_PERIOD     = 4;
  localparam int RESET_CYCLES    = 5;
  localparam int NUM_PHASES      = 12;
  localparam int PHASE_ITEMS     = 60;
  localparam int FLOOD_PHASE     = 1;
  localparam int FLOOD_SUBMITS   = 30;
  localparam int CALM_PHASE      = 3;
  localparam int HOLD_CYCLES     = 120;
  localparam int SETTLE_CYCLES   = 8;
  localparam int STALL_LIMIT     = 1000;
  localparam int NUM_STATUS      = 9;

  localparam logic [OP_W-1:0] OP_UNUSED_LO = OP_W'(OP_DONE + 1);
  localparam logic [OP_W-1:0] OP_UNUSED_HI = '1;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TASK_W-1:0] tid;
    logic [WID_W-1:0]  wid;
  } job_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                push = 1'b0;
  logic                full;
  logic [OP_W-1:0]     op_i = '0;
  logic [TASK_W-1:0]   task_id_i = '0;
  logic [WID_W-1:0]    worker_id_i = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic                assign_valid_o;
  logic [WID_W-1:0]    assign_worker_o;
  logic [TASK_W-1:0]   assign_task_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [MAXW_W-1:0]   cfg_max_workers_i = '0;

  task_worker_dispatcher dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .op_i             (op_i),
    .task_id_i        (task_id_i),
    .worker_id_i      (worker_id_i),
    .empty            (empty),
    .pop              (pop),
    .status_o         (status_o),
    .assign_valid_o   (assign_valid_o),
    .assign_worker_o  (assign_worker_o),
    .assign_task_o    (assign_task_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_max_workers_i(cfg_max_workers_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Jobs waiting to be driven, and results the dispatcher still owes.
  job_t job_q[$];
  res_t due_results[$];

  // Predictor state
  logic [TASK_W-1:0] pend_q[$];
  logic [WID_W-1:0]  idle_q[$];
  int                started_cnt = 0;
  logic [MAXW_W-1:0] max_workers_cfg = MAXW_RESET;

  int errors = 0;
  int n_in = 0;
  int n_out = 0;
  int n_cfg = 0;
  int full_stalls = 0;
  int stall_cycles = 0;
  int idle_pct = 25;
  int hold_asked = 0;
  int hold_done = 0;
  int hold_left = 0;
  logic in_beat = 1'b0;
  logic [NUM_STATUS-1:0] status_seen = '0;

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH result %0d %s: got %0d expected %0d", n_out, what, got, want);
    errors++;
  endtask

  // Hand a task to the oldest idle worker, else start a new one under the cap.
  function automatic bit try_hand_out(input logic [TASK_W-1:0] tid, output res_t r);
    int cap;
    r = '0;
    cap = (max_workers_cfg < WORKER_LIMIT_DEF) ? max_workers_cfg : WORKER_LIMIT_DEF;
    if (idle_q.size() > 0) begin
      r.status        = STS_TO_IDLE;
      r.assign_valid  = 1'b1;
      r.assign_worker = idle_q[0];
      r.assign_task   = tid;
      idle_q.delete(0);
      return 1'b1;
    end
    if (started_cnt < cap) begin
      r.status        = STS_TO_NEW;
      r.assign_valid  = 1'b1;
      r.assign_worker = WID_W'(started_cnt);
      r.assign_task   = tid;
      started_cnt++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic res_t dispatch_step(job_t j);
    res_t r;
    int hit;
    r = '0;
    hit = -1;
    case (j.op)
      OP_SUBMIT: begin
        if (!try_hand_out(j.tid, r)) begin
          if (pend_q.size() < PENDING_DEPTH_DEF) begin
            pend_q.insert(pend_q.size(), j.tid);
            r.status = STS_QUEUED;
          end else begin
            r.status = STS_DROPPED;
          end
        end
      end
      OP_SUBMIT_IMM: begin
        if (!try_hand_out(j.tid, r)) r.status = STS_REJECTED;
      end
      OP_REMOVE: begin
        for (int k = 0; k < pend_q.size(); k++) begin
          if (pend_q[k] == j.tid) begin
            hit = k;
            break;
          end
        end
        if (hit >= 0) begin
          pend_q.delete(hit);
          r.status = STS_REMOVED;
        end else begin
          r.status = STS_NOT_FOUND;
        end
      end
      OP_CLEAR: begin
        pend_q.delete();
        r.status = STS_CLEARED;
      end
      OP_DONE: begin
        if (pend_q.size() > 0) begin
          r.status        = STS_TO_IDLE;
          r.assign_valid  = 1'b1;
          r.assign_worker = j.wid;
          r.assign_task   = pend_q[0];
          pend_q.delete(0);
        end else begin
          // a full idle ring drops the id but still reports idled
          if (idle_q.size() < WORKER_LIMIT_DEF) idle_q.insert(idle_q.size(), j.wid);
          r.status = STS_IDLED;
        end
      end
      default: r.status = STS_REJECTED;
    endcase
    return r;
  endfunction

  // Monitor: predicts on each input beat, checks each result beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_beat <= push && !full;
      if (push && full) full_stalls++;
      if (push && !full) begin
        due_results.insert(due_results.size(),
                           dispatch_step(job_t'{op: op_i, tid: task_id_i, wid: worker_id_i}));
        n_in++;
      end
      if (pop && !empty) begin
        res_t want;
        if (due_results.size() == 0) begin
          report_mismatch("arrived with nothing expected, status", status_o, -1);
        end else begin
          want = due_results[0];
          due_results.delete(0);
          if (status_o < NUM_STATUS) status_seen[status_o] = 1'b1;
          if (status_o != want.status)
            report_mismatch("status", status_o, want.status);
          if (assign_valid_o != want.assign_valid)
            report_mismatch("assign_valid", assign_valid_o, want.assign_valid);
          if (assign_worker_o != want.assign_worker)
            report_mismatch("assign_worker", assign_worker_o, want.assign_worker);
          if (assign_task_o != want.assign_task)
            report_mismatch("assign_task", assign_task_o, want.assign_task);
        end
        n_out++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        max_workers_cfg = cfg_max_workers_i;
        n_cfg++;
      end
    end
  end

  // Driver: holds a beat until it is taken, then maybe idles.
  always @(negedge clk_i) begin
    if (rst_ni && (!push || in_beat)) begin
      if (job_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        job_t cur;
        cur = job_q[0];
        job_q.delete(0);
        push        <= 1'b1;
        op_i        <= cur.op;
        task_id_i   <= cur.tid;
        worker_id_i <= cur.wid;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: random pop, plus a long hold-off on request.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        pop       <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_asked != hold_done) begin
        pop       <= 1'b0;
        hold_left <= HOLD_CYCLES;
        hold_done <= hold_done + 1;
      end else begin
        pop <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic void add_job(logic [OP_W-1:0] op, logic [TASK_W-1:0] tid,
                                  logic [WID_W-1:0] wid);
    job_q.insert(job_q.size(), job_t'{op: op, tid: tid, wid: wid});
  endfunction

  // mode 0 balanced, 1 submit heavy, 2 done heavy; task ids mostly from a
  // small pool so that removes find their target.
  function automatic job_t make_job(int mode, logic [TASK_W-1:0] pool_base);
    int wt[3][6] = '{'{30, 15, 20, 3, 27, 5}, '{60, 10, 15, 2, 10, 3},
                     '{15, 10, 10, 2, 60, 3}};
    op_e ops[5] = '{OP_SUBMIT, OP_SUBMIT_IMM, OP_REMOVE, OP_CLEAR, OP_DONE};
    int pick;
    int acc;
    int k;
    job_t j;
    pick = $urandom_range(0, 99);
    acc = 0;
    for (k = 0; k < 5; k++) begin
      acc += wt[mode][k];
      if (pick < acc) break;
    end
    j.op  = (k < 5) ? ops[k] : OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    j.tid = ($urandom_range(0, 3) != 0) ? pool_base + TASK_W'($urandom_range(0, 15))
                                        : TASK_W'($urandom_range(0, 255));
    j.wid = WID_W'($urandom_range(0, 7));
    return j;
  endfunction

  task automatic write_max_workers(logic [MAXW_W-1:0] value);
    int start;
    start = n_cfg;
    @(negedge clk_i);
    cfg_valid_i       <= 1'b1;
    cfg_max_workers_i <= value;
    while (n_cfg == start) @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain;
    while (job_q.size() != 0 || push || due_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    logic [TASK_W-1:0] base;
    logic [MAXW_W-1:0] cfg_val;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: no workers may start, so everything goes through the queues.
    write_max_workers('0);
    add_job(OP_SUBMIT_IMM, 8'hFF, '0);
    add_job(OP_SUBMIT, 8'h00, '0);
    add_job(OP_SUBMIT, 8'hFF, '0);
    add_job(OP_SUBMIT, 8'h5A, '0);
    add_job(OP_REMOVE, 8'h07, '0);
    add_job(OP_REMOVE, 8'hFF, '0);
    add_job(OP_DONE, 8'h00, 3'd7);
    add_job(OP_DONE, 8'h00, 3'd0);
    add_job(OP_DONE, 8'h00, 3'd0);
    add_job(OP_SUBMIT, 8'hAA, '0);
    add_job(OP_SUBMIT, 8'h11, '0);
    add_job(OP_CLEAR, 8'h00, '0);
    add_job(OP_REMOVE, 8'h11, '0);
    add_job(OP_UNUSED_LO, 8'h00, '0);
    add_job(OP_UNUSED_HI, 8'h00, '0);
    // nine done beats: the last one overflows the idle ring
    for (int w = 0; w < WORKER_LIMIT_DEF; w++) add_job(OP_DONE, 8'h00, WID_W'(w));
    add_job(OP_DONE, 8'h00, 3'd3);
    add_job(OP_SUBMIT_IMM, 8'hFF, '0);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       cfg_val = 4'd1;
        1:       cfg_val = 4'd2;
        2:       cfg_val = '1;
        3:       cfg_val = MAXW_RESET;
        default: cfg_val = MAXW_W'($urandom_range(0, 15));
      endcase
      write_max_workers(cfg_val);
      idle_pct = (ph == CALM_PHASE) ? 0 : 25;
      base = TASK_W'($urandom_range(0, 15) * 16);
      if (ph == FLOOD_PHASE) begin
        // fill the pending store past its depth while results back up
        for (int i = 0; i < FLOOD_SUBMITS; i++)
          add_job(OP_SUBMIT, base + TASK_W'($urandom_range(0, 15)), WID_W'($urandom_range(0, 7)));
        hold_asked++;
      end
      for (int i = 0; i < PHASE_ITEMS - ((ph == FLOOD_PHASE) ? FLOOD_SUBMITS : 0); i++)
        job_q.insert(job_q.size(), make_job(ph % 3, base));
      drain();
    end

    $display("Covered %0d commands and %0d results across %0d max_workers writes",
             n_in, n_out, n_cfg);
    $display("Result codes seen: %0d of %0d; cycles with push held off by full: %0d",
             $countones(status_seen), NUM_STATUS, full_stalls);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
